// ----- design/bbia_pkg.sv -----
// Shared types and constants of the bitmap block and inode allocator.
`default_nettype none

package bbia_pkg;

  // Default map sizes and word width.
  localparam int BBIA_MAX_DATA_BITS  = 65536;
  localparam int BBIA_MAX_INODE_BITS = 8192;
  localparam int BBIA_WORD_BITS      = 64;

  // Fixed field widths of the ports and registers.
  localparam int NUMBER_W      = 32;
  localparam int DATA_COUNT_W  = 17;
  localparam int INODE_COUNT_W = 14;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int TUSER_W       = 8;

  typedef enum logic [1:0] {
    MODE_ALLOC_BLOCK = 2'd0,
    MODE_ALLOC_INODE = 2'd1,
    MODE_FREE_BLOCK  = 2'd2,
    MODE_FREE_INODE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FREE  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_COUNT  = 2'd0,
    CFG_INODE_COUNT = 2'd1,
    CFG_DATA_BASE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_GRANT,
    ST_FETCH,
    ST_FREE_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    mode_e               mode;
    logic [NUMBER_W-1:0] number;
  } req_t;

  typedef struct packed {
    logic [NUMBER_W-1:0] granted;
    status_e             status;
  } rsp_t;

endpackage

`default_nettype wire

// ----- design/bbia_scan.sv -----
// Lowest-clear-bit finder over one map word, limited to the valid low bits.
`default_nettype none

module bbia_scan import bbia_pkg::*; #(
  parameter int WORD_BITS = BBIA_WORD_BITS
) (
  input  wire logic [WORD_BITS-1:0]           word_i,
  input  wire logic [$clog2(WORD_BITS+1)-1:0] lim_i,
  output logic                                found_o,
  output logic [$clog2(WORD_BITS)-1:0]        bit_o,
  output logic [WORD_BITS-1:0]                set_word_o
);

  localparam int LIM_W = $clog2(WORD_BITS+1);
  localparam int WB_W  = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] onehot;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (LIM_W'(i) < lim_i);
    end
  end

  assign free_bits = ~word_i & mask;
  // Two's complement trick isolates the lowest set bit.
  assign onehot    = free_bits & (~free_bits + WORD_BITS'(1));
  assign found_o   = (free_bits != '0);

  always_comb begin
    bit_o = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        bit_o = bit_o | WB_W'(i);
      end
    end
  end

  assign set_word_o = word_i | onehot;

endmodule

`default_nettype wire

// ----- design/bbia_core.sv -----
// Sequencer, map memories and shared word-step datapath of the allocator.
`default_nettype none

module bbia_core import bbia_pkg::*; #(
  parameter int MAX_DATA_BITS  = BBIA_MAX_DATA_BITS,
  parameter int MAX_INODE_BITS = BBIA_MAX_INODE_BITS,
  parameter int WORD_BITS      = BBIA_WORD_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [$clog2(MAX_DATA_BITS+1)-1:0]  dcnt_i,
  input  wire logic [$clog2(MAX_INODE_BITS+1)-1:0] icnt_i,
  input  wire logic [NUMBER_W-1:0]                 data_base_i,
  input  wire logic                                req_valid_i,
  output logic                                     req_ready_o,
  input  wire req_t                                req_i,
  output logic                                     rsp_valid_o,
  input  wire logic                                rsp_ready_i,
  output rsp_t                                     rsp_o
);

  localparam int DATA_WORDS  = (MAX_DATA_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int INODE_WORDS = (MAX_INODE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int MAX_WORDS   = (DATA_WORDS > INODE_WORDS) ? DATA_WORDS : INODE_WORDS;
  localparam int WA_W        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int DA_W        = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int IA_W        = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
  localparam int DCNT_W      = $clog2(MAX_DATA_BITS+1);
  localparam int ICNT_W      = $clog2(MAX_INODE_BITS+1);
  localparam int CNT_W       = (DCNT_W > ICNT_W) ? DCNT_W : ICNT_W;
  localparam int ACC_W       = $clog2(MAX_WORDS*WORD_BITS + 1);
  localparam int WB_W        = $clog2(WORD_BITS);
  localparam int LIM_W       = $clog2(WORD_BITS+1);

  state_e                state_q, state_d;
  mode_e                 mode_q, mode_d;
  logic [NUMBER_W-1:0]   number_q, number_d;
  logic [WA_W-1:0]       w_q, w_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [NUMBER_W-1:0]   granted_q, granted_d;
  status_e               status_q, status_d;

  logic [WORD_BITS-1:0]  data_mem  [DATA_WORDS];
  logic [WORD_BITS-1:0]  inode_mem [INODE_WORDS];
  logic [WORD_BITS-1:0]  d_rdata_q, i_rdata_q;
  logic                  d_we, i_we, map_we;
  logic [WA_W-1:0]       waddr, raddr;
  logic [WORD_BITS-1:0]  wdata;

  logic                  is_inode, is_alloc;
  logic [CNT_W-1:0]      cnt_sel;
  logic                  cnt_zero;
  logic [WORD_BITS-1:0]  rdata;
  logic [NUMBER_W:0]     diff;
  logic                  in_range;
  logic [ACC_W-1:0]      free_idx;
  logic [31:0]           remain;
  logic [LIM_W-1:0]      lim;
  logic [ACC_W-1:0]      acc_next_word;
  logic                  last_word;
  logic                  clr_last;
  logic [WA_W-1:0]       w_inc;
  logic                  found;
  logic [WB_W-1:0]       bit_idx;
  logic [WORD_BITS-1:0]  set_word;

  assign is_inode = (mode_q == MODE_ALLOC_INODE) || (mode_q == MODE_FREE_INODE);
  assign is_alloc = (mode_q == MODE_ALLOC_BLOCK) || (mode_q == MODE_ALLOC_INODE);
  assign cnt_sel  = is_inode ? CNT_W'(icnt_i) : CNT_W'(dcnt_i);
  assign cnt_zero = (cnt_sel == '0);
  assign rdata    = is_inode ? i_rdata_q : d_rdata_q;

  // The block range is checked on 33 bits so that no wrap hides a low number.
  assign diff     = {1'b0, number_q} - {1'b0, data_base_i};
  assign in_range = is_inode ? (number_q < 32'(icnt_i))
                             : (!diff[NUMBER_W] && (diff[NUMBER_W-1:0] < 32'(dcnt_i)));
  assign free_idx = is_inode ? ACC_W'(number_q) : ACC_W'(diff[NUMBER_W-1:0]);

  assign remain        = 32'(cnt_sel) - 32'(acc_q);
  assign lim           = (remain >= 32'(WORD_BITS)) ? LIM_W'(WORD_BITS) : LIM_W'(remain);
  assign acc_next_word = acc_q + ACC_W'(WORD_BITS);
  assign last_word     = (32'(acc_next_word) >= 32'(cnt_sel));
  assign clr_last      = (w_q == WA_W'(MAX_WORDS-1));
  assign w_inc         = w_q + WA_W'(1);

  bbia_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word_i     (rdata),
    .lim_i      (lim),
    .found_o    (found),
    .bit_o      (bit_idx),
    .set_word_o (set_word)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (is_alloc) begin
          state_d = cnt_zero ? ST_DONE : ST_SCAN;
        end else begin
          state_d = in_range ? ST_FETCH : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_d = ST_GRANT;
        end else if (last_word) begin
          state_d = ST_DONE;
        end
      end
      ST_GRANT: state_d = ST_DONE;
      ST_FETCH: state_d = ST_FREE_WR;
      ST_FREE_WR: state_d = ST_DONE;
      ST_DONE: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    mode_d    = mode_q;
    number_d  = number_q;
    w_d       = w_q;
    acc_d     = acc_q;
    granted_d = granted_q;
    status_d  = status_q;
    map_we    = 1'b0;
    d_we      = 1'b0;
    i_we      = 1'b0;
    raddr     = w_q;
    waddr     = w_q;
    wdata     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        d_we = (32'(w_q) < 32'(DATA_WORDS));
        i_we = (32'(w_q) < 32'(INODE_WORDS));
        w_d  = clr_last ? '0 : w_inc;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          mode_d    = req_i.mode;
          number_d  = req_i.number;
          granted_d = '0;
          status_d  = STATUS_OK;
          w_d       = '0;
          acc_d     = '0;
        end
      end
      ST_CHECK: begin
        raddr = '0;
        if (is_alloc) begin
          if (cnt_zero) status_d = STATUS_FULL;
        end else if (!in_range) begin
          status_d = STATUS_RANGE;
        end else begin
          // Word size is a power of two: the upper bits address the word.
          acc_d = free_idx;
          w_d   = WA_W'(free_idx >> WB_W);
        end
      end
      ST_SCAN: begin
        // The next word is fetched while this one is examined.
        raddr = w_inc;
        if (found) begin
          map_we = 1'b1;
          wdata  = set_word;
          acc_d  = acc_q + ACC_W'(bit_idx);
        end else begin
          w_d   = w_inc;
          acc_d = acc_next_word;
          if (last_word) status_d = STATUS_FULL;
        end
      end
      ST_GRANT: begin
        granted_d = is_inode ? 32'(acc_q) : data_base_i + 32'(acc_q);
      end
      ST_FETCH: begin
        // The word holding the bit is read here.
      end
      ST_FREE_WR: begin
        if (!rdata[acc_q[WB_W-1:0]]) begin
          status_d = STATUS_FREE;
        end else begin
          map_we = 1'b1;
          wdata  = rdata & ~(WORD_BITS'(1) << acc_q[WB_W-1:0]);
        end
      end
      ST_DONE: begin
      end
    endcase
    if (map_we) begin
      d_we = !is_inode;
      i_we = is_inode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      w_q     <= '0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    number_q  <= number_d;
    acc_q     <= acc_d;
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      data_mem[waddr[DA_W-1:0]] <= wdata;
    end
    d_rdata_q <= data_mem[raddr[DA_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) begin
      inode_mem[waddr[IA_W-1:0]] <= wdata;
    end
    i_rdata_q <= inode_mem[raddr[IA_W-1:0]];
  end

  assign req_ready_o    = (state_q == ST_IDLE);
  assign rsp_valid_o    = (state_q == ST_DONE);
  assign rsp_o.granted  = granted_q;
  assign rsp_o.status   = status_q;

endmodule

`default_nettype wire

// ----- design/bitmap_block_inode_allocator.sv -----
// Top level of the first-fit bitmap allocator for data blocks and inodes.
//
// Requests arrive one at a time and each is worked on until its result is
// in the output register; s_axis_tready is low meanwhile. An allocation
// goes through the check, scan and grant states; the scan examines map
// words in order, up to DATA_WORDS of them when the only free bit lies in
// the last data word, and the sequencer reads and tests one map word per
// cycle. A map with no free bit skips the grant state. For a free, the
// word address and bit offset are slices of the bit number; the fetch state
// reads that word and the free-write state writes it back. Failed range
// checks and allocations with a zero count go from the check state straight
// to the done state. After reset a clearing pass over max(DATA_WORDS,
// INODE_WORDS) map words (1024 by default) zeroes both maps before the first
// request is taken; configuration writes are taken at any time. The output
// register lets the next request enter while a result still waits to be
// taken.
`default_nettype none

module bitmap_block_inode_allocator import bbia_pkg::*; #(
  parameter int MAX_DATA_BITS  = BBIA_MAX_DATA_BITS,
  parameter int MAX_INODE_BITS = BBIA_MAX_INODE_BITS,
  parameter int WORD_BITS      = BBIA_WORD_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [NUMBER_W-1:0]   s_axis_tdata,   // [31:0] number
  input  wire logic [TUSER_W-1:0]    s_axis_tuser,   // [1:0] mode, [7:2] zero
  // Result stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [NUMBER_W-1:0]        m_axis_tdata,   // [31:0] granted
  output logic [TUSER_W-1:0]         m_axis_tuser,   // [1:0] status, [7:2] zero
  // Configuration writes.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DCNT_W = $clog2(MAX_DATA_BITS+1);
  localparam int ICNT_W = $clog2(MAX_INODE_BITS+1);

  logic [DATA_COUNT_W-1:0]  data_count_q;
  logic [INODE_COUNT_W-1:0] inode_count_q;
  logic [NUMBER_W-1:0]      data_base_q;
  logic [DCNT_W-1:0]        dcnt;
  logic [ICNT_W-1:0]        icnt;

  req_t                     req;
  rsp_t                     rsp;
  logic                     rsp_valid;
  logic                     rsp_ready;

  logic                     m_valid_q;
  logic [NUMBER_W-1:0]      m_data_q;
  status_e                  m_status_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_count_q  <= '0;
      inode_count_q <= '0;
      data_base_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DATA_COUNT:  data_count_q  <= cfg_data_i[DATA_COUNT_W-1:0];
        CFG_INODE_COUNT: inode_count_q <= cfg_data_i[INODE_COUNT_W-1:0];
        CFG_DATA_BASE:   data_base_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Counts above the map capacity saturate to the capacity.
  assign dcnt = (32'(data_count_q) > 32'(MAX_DATA_BITS)) ? DCNT_W'(MAX_DATA_BITS)
                                                         : DCNT_W'(data_count_q);
  assign icnt = (32'(inode_count_q) > 32'(MAX_INODE_BITS)) ? ICNT_W'(MAX_INODE_BITS)
                                                           : ICNT_W'(inode_count_q);

  assign req.mode   = mode_e'(s_axis_tuser[1:0]);
  assign req.number = s_axis_tdata;

  bbia_core #(
    .MAX_DATA_BITS  (MAX_DATA_BITS),
    .MAX_INODE_BITS (MAX_INODE_BITS),
    .WORD_BITS      (WORD_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dcnt_i      (dcnt),
    .icnt_i      (icnt),
    .data_base_i (data_base_q),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  assign rsp_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      m_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      m_data_q   <= rsp.granted;
      m_status_q <= rsp.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = {(TUSER_W-2)'(0), m_status_q};

endmodule

`default_nettype wire

// ----- design/bbia_checker.sv -----
// Port-level checker of the allocator and its bind to the top level.
`default_nettype none

module bbia_checker import bbia_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [NUMBER_W-1:0] m_axis_tdata,
  input wire logic [TUSER_W-1:0]  m_axis_tuser
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Only one request is in flight, so the input closes after a transaction.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // A result passes the check state and the output register before it appears.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after its request");

  // Failed requests never grant a number.
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[1:0] != STATUS_OK)) |-> (m_axis_tdata == '0))
    else $error("failed request returned a nonzero number");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed or dropped");

endmodule

bind bitmap_block_inode_allocator bbia_checker u_bbia_checker (.*);

`default_nettype wire

// ----- dv/bitmap_block_inode_allocator_tb.sv -----
// Self-checking testbench for the first-fit bitmap allocator of data blocks and inodes.
module bitmap_block_inode_allocator_tb import bbia_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_CAP       = BBIA_MAX_DATA_BITS;
  localparam int unsigned INODE_CAP      = BBIA_MAX_INODE_BITS;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 1100;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // Index 3 has no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    mode_e                 mode;
    logic [NUMBER_W-1:0]   value;
    logic                  typed;
    logic [NUMBER_W-1:0]   want_granted;
    status_e               want_status;
  } script_row_t;

  localparam int SCRIPT_LEN = 33;

  // Rows without a typed result are checked against the predictor.
  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'h0000_0000, 1'b1, 32'h0, STATUS_FULL},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_INODE, 32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_FULL},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_BLOCK,  32'h0000_0000, 1'b1, 32'h0, STATUS_RANGE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_INODE,  32'h0000_0000, 1'b1, 32'h0, STATUS_RANGE},
    '{ROW_CFG, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'hFFFF_FFFF, 1'b0, 32'h0, STATUS_OK},
    '{ROW_CFG, CFG_INODE_COUNT, MODE_ALLOC_BLOCK, 32'hFFFF_FFFF, 1'b0, 32'h0, STATUS_OK},
    '{ROW_CFG, CFG_DATA_BASE,   MODE_ALLOC_BLOCK, 32'hFFFF_FFF0, 1'b0, 32'h0, STATUS_OK},
    '{ROW_CFG, CFG_SPARE,       MODE_ALLOC_BLOCK, 32'h1234_5678, 1'b0, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'h0000_0000, 1'b1, 32'hFFFF_FFF0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_INODE, 32'h0000_0000, 1'b1, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_BLOCK,  32'hFFFF_FFF0, 1'b1, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_BLOCK,  32'hFFFF_FFF0, 1'b1, 32'h0, STATUS_FREE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_BLOCK,  32'hFFFF_FFEF, 1'b1, 32'h0, STATUS_RANGE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_BLOCK,  32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_FREE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_INODE,  32'd8191,      1'b1, 32'h0, STATUS_FREE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_INODE,  32'd8192,      1'b1, 32'h0, STATUS_RANGE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_INODE,  32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_RANGE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_INODE,  32'h0000_0000, 1'b1, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'hAAAA_AAAA, 1'b0, 32'h0, STATUS_OK},
    '{ROW_CFG, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'd3,         1'b0, 32'h0, STATUS_OK},
    '{ROW_CFG, CFG_INODE_COUNT, MODE_ALLOC_BLOCK, 32'd2,         1'b0, 32'h0, STATUS_OK},
    '{ROW_CFG, CFG_DATA_BASE,   MODE_ALLOC_BLOCK, 32'd100,       1'b0, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'h5555_5555, 1'b0, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'h0000_0000, 1'b1, 32'h0, STATUS_FULL},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_INODE, 32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_INODE, 32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_INODE, 32'h0000_0000, 1'b1, 32'h0, STATUS_FULL},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_BLOCK,  32'd103,       1'b1, 32'h0, STATUS_RANGE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_BLOCK,  32'd101,       1'b1, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_ALLOC_BLOCK, 32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_INODE,  32'd2,         1'b1, 32'h0, STATUS_RANGE},
    '{ROW_REQ, CFG_DATA_COUNT,  MODE_FREE_BLOCK,  32'd99,        1'b1, 32'h0, STATUS_RANGE}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [NUMBER_W-1:0]   s_axis_tdata  = '0;
  logic [TUSER_W-1:0]    s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [NUMBER_W-1:0]   m_axis_tdata;
  logic [TUSER_W-1:0]    m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  bitmap_block_inode_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predicted allocator state: one flag per block and per inode, set while in use.
  bit                       block_used [DATA_CAP];
  bit                       inode_used [INODE_CAP];
  logic [DATA_COUNT_W-1:0]  data_count_r  = '0;
  logic [INODE_COUNT_W-1:0] inode_count_r = '0;
  logic [NUMBER_W-1:0]      data_base_r   = '0;

  rsp_t                expected_results [$];
  logic [NUMBER_W-1:0] live_blocks [$];
  logic [NUMBER_W-1:0] live_inodes [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_requested = 1'b0;
  int unsigned held_cycles    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned failures       = 0;

  function automatic int unsigned block_limit();
    return (data_count_r > DATA_CAP) ? DATA_CAP : data_count_r;
  endfunction

  function automatic int unsigned inode_limit();
    return (inode_count_r > INODE_CAP) ? INODE_CAP : inode_count_r;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_DATA_COUNT:  data_count_r  = value[DATA_COUNT_W-1:0];
      CFG_INODE_COUNT: inode_count_r = value[INODE_COUNT_W-1:0];
      CFG_DATA_BASE:   data_base_r   = value;
      default: ;
    endcase
  endfunction

  function automatic rsp_t predict_allocation(mode_e mode, logic [NUMBER_W-1:0] number);
    rsp_t                rsp;
    int unsigned         lim;
    int unsigned         slot;
    logic [NUMBER_W-1:0] offset;
    rsp.granted = '0;
    rsp.status  = STATUS_OK;
    case (mode)
      MODE_ALLOC_BLOCK: begin
        lim  = block_limit();
        slot = 0;
        while (slot < lim && block_used[slot]) slot++;
        if (slot < lim) begin
          block_used[slot] = 1'b1;
          rsp.granted      = data_base_r + slot;
        end else begin
          rsp.status = STATUS_FULL;
        end
      end
      MODE_ALLOC_INODE: begin
        lim  = inode_limit();
        slot = 0;
        while (slot < lim && inode_used[slot]) slot++;
        if (slot < lim) begin
          inode_used[slot] = 1'b1;
          rsp.granted      = slot;
        end else begin
          rsp.status = STATUS_FULL;
        end
      end
      MODE_FREE_BLOCK: begin
        // The range test must not wrap: a number below the base is always out of range.
        offset = number - data_base_r;
        if (number < data_base_r || offset >= block_limit()) rsp.status = STATUS_RANGE;
        else if (!block_used[offset]) rsp.status = STATUS_FREE;
        else block_used[offset] = 1'b0;
      end
      MODE_FREE_INODE: begin
        if (number >= inode_limit()) rsp.status = STATUS_RANGE;
        else if (!inode_used[number]) rsp.status = STATUS_FREE;
        else inode_used[number] = 1'b0;
      end
    endcase
    return rsp;
  endfunction

  task automatic send_request(input mode_e mode, input logic [NUMBER_W-1:0] number,
                              input bit typed, input rsp_t typed_rsp, output rsp_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    s_axis_tuser  <= {{(TUSER_W-2){1'b0}}, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_allocation(mode, number);
    expected_results.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_config(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                           input logic [CFG_DATA_W-1:0] dcount,
                           input logic [CFG_DATA_W-1:0] icount,
                           input logic [CFG_DATA_W-1:0] base,
                           input int unsigned n_items, input bit with_hold);
    mode_e               mode;
    logic [NUMBER_W-1:0] number;
    rsp_t                got;
    int unsigned         pick;
    int unsigned         pos;
    wait_idle();
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    write_reg(CFG_DATA_COUNT, dcount);
    write_reg(CFG_INODE_COUNT, icount);
    write_reg(CFG_DATA_BASE, base);
    // Entries still in use from earlier phases stay freeable under the new settings.
    live_blocks.delete();
    live_inodes.delete();
    for (int unsigned i = 0; i < block_limit(); i++)
      if (block_used[i]) live_blocks.push_back(data_base_r + i);
    for (int unsigned i = 0; i < inode_limit(); i++)
      if (inode_used[i]) live_inodes.push_back(i);
    hold_requested = with_hold;
    repeat (n_items) begin
      pick   = $urandom_range(99);
      number = $urandom;
      if (pick < 50) begin
        mode = pick[0] ? MODE_ALLOC_INODE : MODE_ALLOC_BLOCK;
      end else begin
        mode = pick[0] ? MODE_FREE_INODE : MODE_FREE_BLOCK;
        pick = $urandom_range(99);
        if (mode == MODE_FREE_BLOCK) begin
          if (pick < 60 && live_blocks.size() != 0) begin
            pos    = $urandom_range(live_blocks.size() - 1);
            number = live_blocks[pos];
            live_blocks.delete(pos);
          end else if (pick < 88) begin
            number = data_base_r + $urandom_range(block_limit() + 1) - 1;
          end
        end else begin
          if (pick < 60 && live_inodes.size() != 0) begin
            pos    = $urandom_range(live_inodes.size() - 1);
            number = live_inodes[pos];
            live_inodes.delete(pos);
          end else if (pick < 88) begin
            number = $urandom_range(inode_limit());
          end
        end
      end
      send_request(mode, number, 1'b0, '0, got);
      if (got.status == STATUS_OK) begin
        if (mode == MODE_ALLOC_BLOCK) live_blocks.push_back(got.granted);
        else if (mode == MODE_ALLOC_INODE) live_inodes.push_back(got.granted);
      end
    end
  endtask

  initial begin
    rsp_t want;
    rsp_t got;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        want.granted = script[i].want_granted;
        want.status  = script[i].want_status;
        send_request(script[i].mode, script[i].value, script[i].typed, want, got);
      end
    end
    run_phase(0,  0,  40,           20,   $urandom,     105, 1'b0);
    run_phase(53, 0,  130,          64,   $urandom,     105, 1'b0);
    run_phase(0,  53, 7,            1,    32'h0,        105, 1'b1);
    run_phase(11, 11, 200,          300,  32'hFFFF_FFA0, 105, 1'b0);
    run_phase(0,  0,  32'h0001_0000, 8192, $urandom,     30,  1'b0);
    run_phase(11, 11, 1,            8191, 32'hFFFF_FFFF, 100, 1'b0);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("bitmap_block_inode_allocator: match");
    end else begin
      $display("bitmap_block_inode_allocator: mismatch");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that backs up the request side.
  always @(posedge clk_i) begin
    if (hold_requested && held_cycles < HOLD_CYCLES) begin
      m_axis_tready <= 1'b0;
      held_cycles   <= held_cycles + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual granted %h status %0d",
                 $time, m_axis_tdata, m_axis_tuser[1:0]);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata !== want.granted) begin
          $display("%0t: granted expected %h actual %h", $time, want.granted, m_axis_tdata);
          failures++;
        end
        if (m_axis_tuser[1:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser[1:0]);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bitmap_block_inode_allocator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
